### sv/sdpd_pkg.sv
`timescale 1ns / 1ps
// Package for the SECDED (16,11) packet decoder: packet geometry constants,
// word and queue entry types shared by the interfaces and all modules.
// No dependencies.
package sdpd_pkg;

  localparam int PACKET_BYTES = 1024;
  localparam int CODEWORDS    = 504;
  localparam int DATA_BYTES   = 693;

  localparam int POS_W     = $clog2(PACKET_BYTES);
  localparam int CODE_BASE = 8;
  localparam int CODE_END  = CODE_BASE + 2 * CODEWORDS;
  localparam int LAST_POS  = PACKET_BYTES - 1;
  localparam int TAG_FIRST = 4;
  localparam int TAG_LAST  = 7;

  localparam int DAT_W  = 11;
  localparam int ACC_W  = 18;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_CODE  = 2'd1,
    OP_END   = 2'd2
  } op_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_word_t;

  typedef struct packed {
    logic             result_kind;
    logic [7:0]       out_value;
    logic [31:0]      packet_tag;
    logic             packet_status;
    logic [CNT_W-1:0] good_count;
    logic [CNT_W-1:0] open_errors;
    logic             all_sent;
    logic             done_flag;
    logic             last_of_run;
  } out_word_t;

  // One classified work item handed from the front end to the back end.
  typedef struct packed {
    op_t              op;
    logic             ok;
    logic [DAT_W-1:0] dat;
    logic             emit0;
    logic             emit1;
    logic [31:0]      tag;
  } q_entry_t;

  localparam logic RK_DATA   = 1'b0;
  localparam logic RK_STATUS = 1'b1;

endpackage

### sv/sdpd_ifs.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the input byte and result word channels.
// Depends on sdpd_pkg.
interface sdpd_in_if;
  logic               valid;
  logic               ready;
  sdpd_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdpd_out_if;
  logic                valid;
  logic                ready;
  sdpd_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/sdpd_fifo.sv
`timescale 1ns / 1ps
// Short register queue of classified work items between front and back end.
// Depends on sdpd_pkg.
module sdpd_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sdpd_pkg::q_entry_t push_entry,
  input  logic               pop,
  output sdpd_pkg::q_entry_t head,
  output logic               empty,
  output logic               full
);

  sdpd_pkg::q_entry_t             entries [sdpd_pkg::FIFO_DEPTH];
  logic [sdpd_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [sdpd_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [sdpd_pkg::FIFO_AW:0]     count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (sdpd_pkg::FIFO_AW + 1)'(sdpd_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/sdpd_front.sv
`timescale 1ns / 1ps
// Front end: accepts raw bytes, tracks the byte position and tag, decodes
// codeword pairs and queues work items. Depends on sdpd_pkg and sdpd_ifs.
module sdpd_front (
  input  logic               clk,
  input  logic               rst,
  sdpd_in_if.sink            byte_in,
  input  logic               fifo_full,
  output logic               push,
  output sdpd_pkg::q_entry_t push_entry
);

  logic [sdpd_pkg::POS_W-1:0] byte_position;
  logic [31:0]                tag_shift;
  logic [7:0]                 low_code_byte;

  logic [sdpd_pkg::POS_W-1:0] byte_position_next;
  logic [31:0]                tag_shift_next;
  logic [7:0]                 low_code_byte_next;

  logic                       accept;
  logic [sdpd_pkg::POS_W-1:0] pos;
  logic [sdpd_pkg::POS_W-1:0] off;
  logic                       in_code;
  logic [15:0]                word;
  logic [3:0]                 syn;
  logic                       par;
  logic [15:0]                fixed;
  logic [8:0]                 cw_index;
  logic [12:0]                bit_base;
  logic [sdpd_pkg::IDX_W-1:0] out_index;

  assign byte_in.ready = !fifo_full;
  assign accept        = byte_in.valid && byte_in.ready;

  assign pos = byte_in.data.packet_start ? '0 : byte_position;
  assign off = pos - sdpd_pkg::POS_W'(sdpd_pkg::CODE_BASE);
  assign in_code = (pos >= sdpd_pkg::POS_W'(sdpd_pkg::CODE_BASE)) &&
                   ({1'b0, pos} < (sdpd_pkg::POS_W + 1)'(sdpd_pkg::CODE_END)) &&
                   (pos < sdpd_pkg::POS_W'(sdpd_pkg::LAST_POS));

  assign word = {byte_in.data.data_byte, low_code_byte};

  // Syndrome is the XOR of the positions of all set bits; bit 0 carries
  // the overall parity.
  always_comb begin
    syn = '0;
    par = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (word[i]) begin
        syn = syn ^ 4'(i);
        par = ~par;
      end
    end
  end

  assign fixed = word ^ (16'd1 << syn);

  // Index of the first output byte of this codeword: floor(k * 11 / 8).
  assign cw_index  = off[sdpd_pkg::POS_W-1:1];
  assign bit_base  = {1'b0, cw_index, 3'b000} + {3'b000, cw_index, 1'b0} +
                     {4'b0000, cw_index};
  assign out_index = bit_base[12:3];

  always_comb begin
    byte_position_next = byte_position;
    tag_shift_next     = tag_shift;
    low_code_byte_next = low_code_byte;
    push               = 1'b0;
    push_entry.op      = sdpd_pkg::OP_CLEAR;
    push_entry.ok      = (syn == '0) || par;
    push_entry.dat     = {fixed[15:9], fixed[7:5], fixed[3]};
    push_entry.emit0   = ({1'b0, out_index} < (sdpd_pkg::IDX_W + 1)'(sdpd_pkg::DATA_BYTES));
    push_entry.emit1   = (({1'b0, out_index} + 1'b1) <
                          (sdpd_pkg::IDX_W + 1)'(sdpd_pkg::DATA_BYTES));
    push_entry.tag     = tag_shift;
    if (accept) begin
      if (pos == '0) begin
        tag_shift_next     = '0;
        low_code_byte_next = '0;
        push               = 1'b1;
        push_entry.op      = sdpd_pkg::OP_CLEAR;
      end
      if (pos >= sdpd_pkg::POS_W'(sdpd_pkg::TAG_FIRST) &&
          pos <= sdpd_pkg::POS_W'(sdpd_pkg::TAG_LAST)) begin
        tag_shift_next = {byte_in.data.data_byte, tag_shift[31:8]};
      end else if (in_code) begin
        if (!off[0]) begin
          low_code_byte_next = byte_in.data.data_byte;
        end else begin
          push          = 1'b1;
          push_entry.op = sdpd_pkg::OP_CODE;
        end
      end
      if (pos == sdpd_pkg::POS_W'(sdpd_pkg::LAST_POS)) begin
        push               = 1'b1;
        push_entry.op      = sdpd_pkg::OP_END;
        byte_position_next = '0;
      end else begin
        byte_position_next = pos + 1'b1;
      end
      push_entry.tag = tag_shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      tag_shift     <= '0;
      low_code_byte <= '0;
    end else begin
      byte_position <= byte_position_next;
      tag_shift     <= tag_shift_next;
      low_code_byte <= low_code_byte_next;
    end
  end

endmodule

### sv/sdpd_back.sv
`timescale 1ns / 1ps
// Back end: packs decoded data bits into bytes, keeps the packet counters
// and drives the registered result channel. Depends on sdpd_pkg, sdpd_ifs.
module sdpd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [sdpd_pkg::CNT_W-1:0]   cfg_wr_data,
  input  sdpd_pkg::q_entry_t           head,
  input  logic                         empty,
  output logic                         pop,
  sdpd_out_if.source                   result_out
);

  logic [sdpd_pkg::ACC_W-1:0] bit_accumulator, bit_accumulator_next;
  logic [2:0]                 pending_bits, pending_bits_next;
  logic                       packet_failed, packet_failed_next;
  logic                       second_due, second_due_next;
  logic [7:0]                 second_byte, second_byte_next;
  logic [sdpd_pkg::CNT_W-1:0] seen_packets, seen_packets_next;
  logic [sdpd_pkg::CNT_W-1:0] good_packets, good_packets_next;
  logic [sdpd_pkg::CNT_W-1:0] error_total, error_total_next;
  logic                       sent_flag, sent_flag_next;
  logic [sdpd_pkg::CNT_W-1:0] expected_packets;
  logic                       out_valid;
  sdpd_pkg::out_word_t        out_data, out_data_next;
  logic                       load;

  logic                       slot_free;
  logic [sdpd_pkg::ACC_W-1:0] acc_merged;
  logic [4:0]                 total_bits;
  logic                       two_bytes;
  logic                       em1;

  function automatic logic [sdpd_pkg::CNT_W-1:0] sat_inc(
    input logic [sdpd_pkg::CNT_W-1:0] v
  );
    return (v != '1) ? v + 1'b1 : v;
  endfunction

  assign result_out.valid = out_valid;
  assign result_out.data  = out_data;
  assign slot_free        = !out_valid || result_out.ready;

  assign acc_merged = bit_accumulator |
                      (sdpd_pkg::ACC_W'(head.dat) << pending_bits);
  assign total_bits = {2'b00, pending_bits} + 5'(sdpd_pkg::DAT_W);
  assign two_bytes  = (total_bits >= 5'd16);
  assign em1        = two_bytes && head.emit1;

  always_comb begin
    bit_accumulator_next = bit_accumulator;
    pending_bits_next    = pending_bits;
    packet_failed_next   = packet_failed;
    second_due_next      = second_due;
    second_byte_next     = second_byte;
    seen_packets_next    = seen_packets;
    good_packets_next    = good_packets;
    error_total_next     = error_total;
    sent_flag_next       = sent_flag;
    pop                  = 1'b0;
    load                 = 1'b0;
    out_data_next               = '0;
    out_data_next.result_kind   = sdpd_pkg::RK_DATA;
    out_data_next.packet_tag    = head.tag;
    if (!empty) begin
      unique case (head.op)
        sdpd_pkg::OP_CLEAR: begin
          bit_accumulator_next = '0;
          pending_bits_next    = '0;
          packet_failed_next   = 1'b0;
          pop                  = 1'b1;
        end
        sdpd_pkg::OP_CODE: begin
          if (second_due) begin
            if (slot_free) begin
              load                      = 1'b1;
              out_data_next.out_value   = second_byte;
              out_data_next.last_of_run = 1'b1;
              second_due_next           = 1'b0;
              pop                       = 1'b1;
            end
          end else if (packet_failed) begin
            pop = 1'b1;
          end else if (!head.ok) begin
            packet_failed_next = 1'b1;
            pop                = 1'b1;
          end else if (!head.emit0 || slot_free) begin
            if (two_bytes) begin
              bit_accumulator_next = acc_merged >> 16;
              pending_bits_next    = 3'(total_bits - 5'd16);
            end else begin
              bit_accumulator_next = acc_merged >> 8;
              pending_bits_next    = 3'(total_bits - 5'd8);
            end
            if (head.emit0) begin
              load                      = 1'b1;
              out_data_next.out_value   = acc_merged[7:0];
              out_data_next.last_of_run = !em1;
            end
            if (head.emit0 && em1) begin
              second_due_next  = 1'b1;
              second_byte_next = acc_merged[15:8];
            end else begin
              pop = 1'b1;
            end
          end
        end
        sdpd_pkg::OP_END: begin
          if (slot_free) begin
            if (packet_failed) begin
              if (!sent_flag) begin
                error_total_next  = sat_inc(error_total);
                seen_packets_next = sat_inc(seen_packets);
              end
            end else begin
              good_packets_next = sat_inc(good_packets);
              if (!sent_flag) begin
                seen_packets_next = sat_inc(seen_packets);
              end else if (error_total != '0) begin
                error_total_next = error_total - 1'b1;
              end
            end
            if (!sent_flag && seen_packets_next == expected_packets) begin
              sent_flag_next = 1'b1;
            end
            load                        = 1'b1;
            pop                         = 1'b1;
            out_data_next.result_kind   = sdpd_pkg::RK_STATUS;
            out_data_next.packet_status = packet_failed;
            out_data_next.good_count    = good_packets_next;
            out_data_next.open_errors   = error_total_next;
            out_data_next.all_sent      = sent_flag_next;
            out_data_next.done_flag     = sent_flag_next && (error_total_next == '0);
            out_data_next.last_of_run   = 1'b1;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= out_data_next;
    end
    second_byte <= second_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accumulator  <= '0;
      pending_bits     <= '0;
      packet_failed    <= 1'b0;
      second_due       <= 1'b0;
      seen_packets     <= '0;
      good_packets     <= '0;
      error_total      <= '0;
      sent_flag        <= 1'b0;
      expected_packets <= sdpd_pkg::CNT_W'(1);
      out_valid        <= 1'b0;
    end else begin
      bit_accumulator <= bit_accumulator_next;
      pending_bits    <= pending_bits_next;
      packet_failed   <= packet_failed_next;
      second_due      <= second_due_next;
      seen_packets    <= seen_packets_next;
      good_packets    <= good_packets_next;
      error_total     <= error_total_next;
      sent_flag       <= sent_flag_next;
      if (cfg_wr_en) begin
        expected_packets <= cfg_wr_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/secded_16_11_packet_decoder_unit.sv
`timescale 1ns / 1ps
// A result word passes through the queue and the result register; the second
// data byte of a codeword follows as a later word. Throughput: one input byte
// per cycle while the queue has space; the result register issues one word per
// cycle while the receiver is ready, so a codeword that yields two bytes holds
// the back end until both words are issued. Reset (rst, synchronous, active
// high) clears position, tag, counters and the queue, and sets expected_packets to 1.
module secded_16_11_packet_decoder_unit (
  input  logic         clk,
  input  logic         rst,
  sdpd_in_if.sink      byte_in,
  sdpd_out_if.source   result_out,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  // The front end only needs queue space to take a byte. Bytes that change
  // nothing downstream (header bytes, the low half of a codeword) never
  // enter the queue, so the back end sees roughly one item per two bytes.
  logic               push;
  logic               pop;
  logic               fifo_full;
  logic               fifo_empty;
  sdpd_pkg::q_entry_t push_entry;
  sdpd_pkg::q_entry_t head;

  // Front end: byte position, tag capture and the syndrome decode of each
  // completed codeword. A work item carries the tag that was current when
  // it was queued, so status words keep the tag of their own packet.
  sdpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouples the two halves so that an output stall does not stop intake
  // until the queue fills.
  sdpd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (fifo_empty),
    .full       (fifo_full)
  );

  // Back end: bit packing, the failure flag that suppresses output after an
  // uncorrectable codeword, end of packet counters and the result register.
  sdpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .empty       (fifo_empty),
    .pop         (pop),
    .result_out  (result_out)
  );

endmodule

### sv/sdpd_checker.sv
`timescale 1ns / 1ps
// Port level checks for the packet decoder and the bind that attaches them.
// Depends on sdpd_pkg and secded_16_11_packet_decoder_unit.
module sdpd_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input sdpd_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == sdpd_pkg::RK_DATA |->
      !out_data.packet_status && out_data.good_count == '0 &&
      out_data.open_errors == '0 && !out_data.all_sent && !out_data.done_flag)
    else $error("data word carries status fields");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == sdpd_pkg::RK_STATUS |->
      out_data.last_of_run && out_data.out_value == '0)
    else $error("status word is not the last of its byte");

  a_done_sent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_flag |-> out_data.all_sent &&
      out_data.open_errors == '0)
    else $error("done reported before all packets were sent");

endmodule

bind secded_16_11_packet_decoder_unit sdpd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_data  (result_out.data)
);

### tb/sv/tb_secded_16_11_packet_decoder_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SECDED (16,11) packet decoder unit: it drives
// byte words, predicts every result word and compares them field by field.
// Depends on sdpd_pkg, the stream interfaces and the decoder top level.
module tb_secded_16_11_packet_decoder_unit;

  // Kinds of generated packet contents. Clean and fixable packets are the
  // well-formed bulk; broken and noise packets exercise the failure path.
  typedef enum int {
    PK_CLEAN,
    PK_FIXABLE,
    PK_BROKEN,
    PK_NOISE
  } pkt_kind_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  sdpd_in_if  byte_in ();
  sdpd_out_if result_out ();

  secded_16_11_packet_decoder_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .byte_in     (byte_in),
    .result_out  (result_out),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Idle and stall rates in percent, changed between the test phases.
  int unsigned send_idle_pct  = 31;
  int unsigned take_stall_pct = 52;

  // The next generated packet must carry packet_start because the decoder
  // sits somewhere in the middle of a packet.
  logic need_start = 1'b1;

  // Result words that the decoder still owes, oldest first.
  sdpd_pkg::out_word_t awaited_words[$];

  int unsigned mismatches        = 0;
  int unsigned bytes_taken       = 0;
  int unsigned data_words_seen   = 0;
  int unsigned status_words_seen = 0;

  // Shadow copy of the decoder state, advanced once per accepted byte word.
  logic [9:0]  dec_pos;
  logic [31:0] dec_tag;
  logic [7:0]  dec_low;
  logic [17:0] dec_acc;
  logic [2:0]  dec_pend;
  logic        dec_failed;
  logic [15:0] dec_seen;
  logic [15:0] dec_good;
  logic [15:0] dec_errs;
  logic        dec_sent;
  logic [15:0] dec_expected;

  function automatic logic [15:0] sat_up(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Syndrome decode of one codeword. Returns 0 for an uncorrectable word,
  // otherwise 1 with the eleven data bits taken from the non power-of-two
  // positions after the single-bit fix.
  function automatic logic correct_codeword(input logic [15:0] cw,
                                            output logic [10:0] dat);
    logic [3:0]  syn;
    logic        par;
    logic [15:0] w;
    int          n;
    syn = '0;
    par = 1'b0;
    n   = 0;
    dat = '0;
    for (int i = 0; i < 16; i++) begin
      if (cw[i]) begin
        syn ^= 4'(i);
        par ^= 1'b1;
      end
    end
    if (syn != 4'd0 && !par) return 1'b0;
    w = cw ^ (16'd1 << syn);
    for (int i = 1; i < 16; i++) begin
      if ((i & (i - 1)) != 0) begin
        dat[n] = w[i];
        n++;
      end
    end
    return 1'b1;
  endfunction

  // Builds a valid extended Hamming codeword for stimulus: data at the non
  // power-of-two positions, check bits at 1, 2, 4, 8, overall parity at 0.
  function automatic logic [15:0] encode_word(input logic [10:0] d);
    logic [15:0] w;
    logic [3:0]  syn;
    int          n;
    w   = '0;
    syn = '0;
    n   = 0;
    for (int i = 1; i < 16; i++) begin
      if ((i & (i - 1)) != 0) begin
        w[i] = d[n];
        n++;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (w[i]) syn ^= 4'(i);
    end
    w[1] = syn[0];
    w[2] = syn[1];
    w[4] = syn[2];
    w[8] = syn[3];
    w[0] = ^w[15:1];
    return w;
  endfunction

  // Advances the shadow state by one accepted byte word and queues the result
  // words that it causes: up to two decoded bytes, or the packet status.
  task automatic predict_byte_results(input logic [7:0] b, input logic st);
    sdpd_pkg::out_word_t made [3];
    int                  n;
    int unsigned         p, off, idx, total;
    logic [10:0]         dat;
    n = 0;
    if (st) dec_pos = '0;
    p = 32'(dec_pos);
    if (p == 0) begin
      dec_tag    = '0;
      dec_low    = '0;
      dec_acc    = '0;
      dec_pend   = '0;
      dec_failed = 1'b0;
    end
    if (p >= sdpd_pkg::TAG_FIRST && p <= sdpd_pkg::TAG_LAST) begin
      // The tag arrives little-endian, so each byte enters at the top.
      dec_tag = {b, dec_tag[31:8]};
    end else if (p >= sdpd_pkg::CODE_BASE && p < sdpd_pkg::CODE_END &&
                 p < sdpd_pkg::LAST_POS) begin
      off = p - sdpd_pkg::CODE_BASE;
      if (!off[0]) begin
        dec_low = b;
      end else if (!dec_failed) begin
        if (!correct_codeword({b, dec_low}, dat)) begin
          dec_failed = 1'b1;
        end else begin
          idx     = ((off >> 1) * 11) >> 3;
          total   = 32'(dec_pend) + 11;
          dec_acc = dec_acc | (18'(dat) << dec_pend);
          while (total >= 8) begin
            if (idx < sdpd_pkg::DATA_BYTES) begin
              made[n]             = '0;
              made[n].result_kind = sdpd_pkg::RK_DATA;
              made[n].out_value   = dec_acc[7:0];
              made[n].packet_tag  = dec_tag;
              n++;
            end
            idx++;
            dec_acc = dec_acc >> 8;
            total   = total - 8;
          end
          dec_pend = total[2:0];
        end
      end
    end
    if (p >= sdpd_pkg::LAST_POS) begin
      if (dec_failed) begin
        if (!dec_sent) begin
          dec_errs = sat_up(dec_errs);
          dec_seen = sat_up(dec_seen);
        end
      end else begin
        dec_good = sat_up(dec_good);
        if (!dec_sent) dec_seen = sat_up(dec_seen);
        else if (dec_errs != 16'd0) dec_errs = dec_errs - 16'd1;
      end
      if (!dec_sent && dec_seen == dec_expected) dec_sent = 1'b1;
      made[n]               = '0;
      made[n].result_kind   = sdpd_pkg::RK_STATUS;
      made[n].packet_tag    = dec_tag;
      made[n].packet_status = dec_failed;
      made[n].good_count    = dec_good;
      made[n].open_errors   = dec_errs;
      made[n].all_sent      = dec_sent;
      made[n].done_flag     = dec_sent && (dec_errs == 16'd0);
      n++;
      dec_pos = '0;
    end else begin
      dec_pos = 10'(p + 1);
    end
    if (n > 0) made[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) awaited_words.push_back(made[i]);
  endtask

  // Offers one byte word after a random gap and holds it until the decoder
  // takes it. Returns right after the accepting edge with valid still high,
  // so back-to-back words are offered without a gap.
  task automatic send_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      byte_in.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    byte_in.valid             <= 1'b1;
    byte_in.data.data_byte    <= b;
    byte_in.data.packet_start <= st;
    do @(posedge clk); while (!byte_in.ready);
    bytes_taken++;
    predict_byte_results(b, st);
  endtask

  // Lowers valid and waits until every owed result word has arrived, then
  // lets the pipeline run on for words that produce no result.
  task automatic settle();
    @(negedge clk);
    byte_in.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_expected(input logic [15:0] v);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    dec_expected = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Generates one packet of the given kind and sends its first span bytes.
  // A packet cut short leaves the decoder mid-packet, so the next packet
  // must start with packet_start.
  task automatic send_packet(input pkt_kind_t kind, input int span);
    logic [7:0]  raw [sdpd_pkg::PACKET_BYTES];
    logic [15:0] cw;
    int          bad_at, flip_a;
    logic        mark;
    bad_at = $urandom_range(sdpd_pkg::CODEWORDS - 1);
    mark   = need_start | 1'($urandom_range(1));
    for (int i = 0; i < sdpd_pkg::PACKET_BYTES; i++) raw[i] = 8'($urandom);
    for (int c = 0; c < sdpd_pkg::CODEWORDS; c++) begin
      cw = encode_word(11'($urandom));
      if (kind == PK_NOISE) begin
        cw = 16'($urandom);
      end else if (kind == PK_BROKEN && c == bad_at) begin
        // Two distinct flipped bits always give a nonzero syndrome with
        // even parity, which the decoder must reject.
        flip_a     = $urandom_range(15);
        cw[flip_a] = ~cw[flip_a];
        flip_a     = (flip_a + $urandom_range(15, 1)) % 16;
        cw[flip_a] = ~cw[flip_a];
      end else if (kind != PK_CLEAN && $urandom_range(7) == 0) begin
        flip_a     = $urandom_range(15);
        cw[flip_a] = ~cw[flip_a];
      end
      raw[sdpd_pkg::CODE_BASE + 2 * c]     = cw[7:0];
      raw[sdpd_pkg::CODE_BASE + 2 * c + 1] = cw[15:8];
    end
    for (int i = 0; i < span; i++) send_byte(raw[i], (i == 0) ? mark : 1'b0);
    need_start = (span < sdpd_pkg::PACKET_BYTES);
  endtask

  function automatic pkt_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return PK_CLEAN;
    if (r < 60) return PK_FIXABLE;
    if (r < 85) return PK_BROKEN;
    return PK_NOISE;
  endfunction

  // Short hand-made sequence: header and tag extremes, the all-zero and
  // all-one codewords, a fix in the overall parity bit, in a data bit and in
  // a check bit, a double error that ends output for the packet, a word
  // after the failure, and a packet start in the middle of a packet.
  task automatic test_directed();
    logic [15:0] cws [7];
    cws[0] = 16'h0000;
    cws[1] = 16'hFFFF;
    cws[2] = encode_word(11'h555) ^ 16'h0001;
    cws[3] = encode_word(11'h2AA) ^ 16'h8000;
    cws[4] = encode_word(11'h7FF) ^ 16'h0100;
    cws[5] = encode_word(11'h001) ^ 16'h1008;
    cws[6] = encode_word(11'h123);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    foreach (cws[k]) begin
      send_byte(cws[k][7:0], 1'b0);
      send_byte(cws[k][15:8], 1'b0);
    end
    send_byte(8'hA5, 1'b1);
    need_start = 1'b1;
  endtask

  // Packets of random content that a packet start cuts short after 100 to
  // 300 bytes: they carry decoded data words but never a status word.
  task automatic test_cut_packets(input int count);
    for (int i = 0; i < count; i++) begin
      send_packet(pick_kind(), $urandom_range(300, 100));
    end
  endtask

  // One complete packet with single-bit fixes. With an expected count of one
  // its status word reports all packets sent and the transfer done.
  task automatic test_full_packet();
    write_expected(16'd1);
    send_packet(PK_FIXABLE, sdpd_pkg::PACKET_BYTES);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    byte_in.valid <= 1'b0;
    while (awaited_words.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (awaited_words.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time,
               awaited_words.size());
      mismatches++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // The receiver decides its ready for the next edge at every falling edge.
  always @(negedge clk) begin
    result_out.ready <= ($urandom_range(99) >= take_stall_pct);
  end

  // Every accepted result word is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    sdpd_pkg::out_word_t want, got;
    if (!rst && result_out.valid && result_out.ready) begin
      got = result_out.data;
      if (got.result_kind == sdpd_pkg::RK_STATUS) status_words_seen++;
      else data_words_seen++;
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual 0x%0h", $time, got);
        mismatches++;
      end else begin
        want = awaited_words.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
        check_field("out_value", 32'(want.out_value), 32'(got.out_value));
        check_field("packet_tag", want.packet_tag, got.packet_tag);
        check_field("packet_status", 32'(want.packet_status), 32'(got.packet_status));
        check_field("good_count", 32'(want.good_count), 32'(got.good_count));
        check_field("open_errors", 32'(want.open_errors), 32'(got.open_errors));
        check_field("all_sent", 32'(want.all_sent), 32'(got.all_sent));
        check_field("done_flag", 32'(want.done_flag), 32'(got.done_flag));
        check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      end
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    byte_in.valid    = 1'b0;
    byte_in.data     = '0;
    result_out.ready = 1'b0;
    dec_pos          = '0;
    dec_tag          = '0;
    dec_low          = '0;
    dec_acc          = '0;
    dec_pend         = '0;
    dec_failed       = 1'b0;
    dec_seen         = '0;
    dec_good         = '0;
    dec_errs         = '0;
    dec_sent         = 1'b0;
    dec_expected     = 16'd1;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // First phase: sender idles often, receiver stalls more than half the time.
    send_idle_pct  = 31;
    take_stall_pct = 52;
    test_directed();
    test_cut_packets(2);

    // Second phase: the rates swap.
    send_idle_pct  = 52;
    take_stall_pct = 31;
    test_cut_packets(2);

    // Last phase: full rate on both sides.
    send_idle_pct  = 0;
    take_stall_pct = 0;
    test_full_packet();

    drain_results();
    $display("Sent %0d byte words; checked %0d decoded data words and %0d status words,",
             bytes_taken, data_words_seen, status_words_seen);
    $display("covering bit fixes, a double error, early packet starts and one full packet.");
    if (mismatches == 0) begin
      $display("PASS secded_16_11_packet_decoder_unit");
    end else begin
      $display("FAIL secded_16_11_packet_decoder_unit");
    end
    $finish;
  end

  // Backstop: a correct run needs well under a tenth of this time.
  initial begin
    #10_000_000;
    $display("Timeout with %0d result words outstanding", awaited_words.size());
    $display("FAIL secded_16_11_packet_decoder_unit");
    $finish;
  end

endmodule
